// ===== hdl/cc20_pkg.sv =====
package cc20_pkg;

    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = 16;
    localparam int BLOCK_BYTES   = 64;
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR  = 3'd6;

    // "expand 32-byte k"
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] block_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       restart;
        logic       message_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last;
    } out_item_t;

endpackage

// ===== hdl/cc20_core.sv =====
// Iterative block function: one quarter round per cycle on a shared unit,
// then a feed-forward add sweep over the 16 words, one word per cycle.
module cc20_core import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  block_t state_in,
    output logic   done,
    output block_t ks_out
);

    localparam int QR_COUNT = DOUBLE_ROUNDS * 8;
    localparam int QR_W     = $clog2(QR_COUNT);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD} state_t;

    state_t           state_reg;
    logic [QR_W-1:0]  qr_reg;
    logic [3:0]       add_idx_reg;
    block_t           work_reg;
    logic             done_reg;

    // quarter round operand selection
    logic [1:0] col;
    logic       diag;
    logic [3:0] ia, ib, ic, id;
    word_t      a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;

    always_comb begin
        col  = qr_reg[1:0];
        diag = qr_reg[2];
        ia = {2'b00, col};
        ib = {2'b01, diag ? col + 2'd1 : col};
        ic = {2'b10, diag ? col + 2'd2 : col};
        id = {2'b11, diag ? col + 2'd3 : col};
        a0 = work_reg[ia];
        b0 = work_reg[ib];
        c0 = work_reg[ic];
        d0 = work_reg[id];
        a1 = a0 + b0;
        d1 = d0 ^ a1; d1 = {d1[15:0], d1[31:16]};
        c1 = c0 + d1;
        b1 = b0 ^ c1; b1 = {b1[19:0], b1[31:20]};
        a2 = a1 + b1;
        d2 = d1 ^ a2; d2 = {d2[23:0], d2[31:24]};
        c2 = c1 + d2;
        b2 = b1 ^ c2; b2 = {b2[24:0], b2[31:25]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            qr_reg      <= '0;
            add_idx_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        work_reg  <= state_in;
                        qr_reg    <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    work_reg[ia] <= a2;
                    work_reg[ib] <= b2;
                    work_reg[ic] <= c2;
                    work_reg[id] <= d2;
                    if (qr_reg == QR_W'(QR_COUNT - 1)) begin
                        add_idx_reg <= '0;
                        state_reg   <= ST_ADD;
                    end else begin
                        qr_reg <= qr_reg + 1'b1;
                    end
                end
                ST_ADD: begin
                    work_reg[add_idx_reg] <= work_reg[add_idx_reg] + state_in[add_idx_reg];
                    add_idx_reg <= add_idx_reg + 1'b1;
                    if (add_idx_reg == 4'd15) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign ks_out = work_reg;

    a_done_after_add: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg) == ST_ADD) else $error("done without add sweep");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |=> (state_reg == ST_ROUND || state_reg == ST_ADD))
        else $error("round sequence broken");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done longer than one cycle");

endmodule

// ===== hdl/chacha20_keystream_xor.sv =====
// Channel  | Ports                                   | Accepted when
// ---------+-----------------------------------------+------------------------
// input    | s_valid, s_ready, s_item                | s_valid && s_ready
// result   | m_valid, m_ready, m_item                | m_valid && m_ready
// config   | cfg_we, cfg_index, cfg_data             | cfg_we
//
// A byte from the current keystream block is accepted in IDLE and then
// registered into the result in OUT. A byte that needs a new block waits for
// the round core: its quarter rounds, then its feed-forward add sweep.
// Reset is synchronous active low and loads the state from zeroed registers.
// Items overlap: the result waits in m_item under m_ready as a new one enters.
module chacha20_keystream_xor import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_GEN, ST_OUT, ST_HOLD} state_t;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_lo_reg, ctr_reg;
    logic [31:0] nonce_hi_reg;

    state_t     state_reg;
    block_t     bstate_reg, bstate_next;
    logic [6:0] pos_reg;
    in_item_t   item_reg;
    out_item_t  m_item_reg;
    logic       m_valid_reg;

    logic       core_start;
    logic       core_done;
    block_t     ks_block;
    logic [5:0] p;
    word_t      ks_word;
    logic [7:0] ks_byte;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0; key3_reg <= '0;
            nonce_lo_reg <= '0; nonce_hi_reg <= '0; ctr_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_0:     key0_reg     <= cfg_data;
                REG_KEY_1:     key1_reg     <= cfg_data;
                REG_KEY_2:     key2_reg     <= cfg_data;
                REG_KEY_3:     key3_reg     <= cfg_data;
                REG_NONCE_LOW: nonce_lo_reg <= cfg_data;
                REG_NONCE_HI:  nonce_hi_reg <= cfg_data[31:0];
                REG_INIT_CTR:  ctr_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // initial state built from the register values
    function automatic block_t load_state(
        input logic [63:0] k0, k1, k2, k3, nlo, ctr, input logic [31:0] nhi);
        block_t s;
        s[0] = SIGMA_0; s[1] = SIGMA_1; s[2] = SIGMA_2; s[3] = SIGMA_3;
        s[4] = k0[31:0]; s[5] = k0[63:32]; s[6] = k1[31:0]; s[7] = k1[63:32];
        s[8] = k2[31:0]; s[9] = k2[63:32]; s[10] = k3[31:0]; s[11] = k3[63:32];
        s[12] = ctr[31:0];
        s[13] = nlo[31:0] + ctr[63:32];
        s[14] = nlo[63:32];
        s[15] = nhi;
        return s;
    endfunction

    cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (core_start),
        .state_in (bstate_reg),
        .done     (core_done),
        .ks_out   (ks_block)
    );

    // keystream byte select
    always_comb begin
        p       = pos_reg[5:0];
        ks_word = ks_block[p[5:2]];
        ks_byte = ks_word[{p[1:0], 3'b000} +: 8];
    end

    // counter bump after a block is generated
    always_comb begin
        bstate_next     = bstate_reg;
        bstate_next[12] = bstate_reg[12] + 32'd1;
        if (bstate_reg[12] == 32'hffffffff)
            bstate_next[13] = bstate_reg[13] + 32'd1;
    end

    // one start pulse per block, the core is idle whenever GEN is entered
    assign core_start = (state_reg == ST_GEN);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 7'd64;
            m_valid_reg <= 1'b0;
            bstate_reg  <= load_state('0, '0, '0, '0, '0, '0, '0);
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT))
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg <= s_item;
                        if (s_item.restart) begin
                            bstate_reg <= load_state(key0_reg, key1_reg, key2_reg, key3_reg,
                                                     nonce_lo_reg, ctr_reg, nonce_hi_reg);
                            pos_reg    <= 7'd64;
                            state_reg  <= ST_GEN;
                        end else if (pos_reg[6]) begin
                            state_reg <= ST_GEN;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_GEN: begin
                    // core start issued here; wait in HOLD for done
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (core_done) begin
                        bstate_reg <= bstate_next;
                        pos_reg    <= 7'd0;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg.data_out <= item_reg.data_in ^ ks_byte;
                        m_item_reg.last     <= item_reg.message_end;
                        m_valid_reg         <= 1'b1;
                        pos_reg             <= pos_reg + 7'd1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> !pos_reg[6]) else $error("byte position past block");
    a_gen_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && core_done) |=> (pos_reg == 7'd0))
        else $error("position not reset after new block");
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result not from output step");

endmodule
